### rtl/ipfl_pkg.sv
// ----------------------------------------------------------------------------
// ipfl_pkg
// Types and constants shared by the parameter field lexer modules.
// ----------------------------------------------------------------------------
package ipfl_pkg;

  localparam int unsigned SigW  = 60;
  localparam int unsigned ExpW  = 15;
  localparam int unsigned AccW  = 34;
  localparam int unsigned ScW   = 16;
  localparam int unsigned XacW  = 14;
  localparam int unsigned MaxRes = 3;

  localparam logic [AccW-1:0] AccCap = 34'h2_0000_0000;
  localparam logic [ScW-1:0]  Sat16  = 16'd16383;

  localparam logic CFG_FIELD_SEP = 1'b0;
  localparam logic CFG_REC_SEP   = 1'b1;

  typedef enum logic [2:0] {
    KIND_DEFAULT = 3'd0,
    KIND_INT     = 3'd1,
    KIND_REAL    = 3'd2,
    KIND_SCHAR   = 3'd3,
    KIND_SDONE   = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_BAD_INT  = 4'd1,
    ERR_BAD_REAL = 4'd2,
    ERR_COUNT    = 4'd3,
    ERR_OVERFLOW = 4'd4,
    ERR_CTRL     = 4'd5,
    ERR_END      = 4'd6,
    ERR_PAST     = 4'd7,
    ERR_RANGE    = 4'd8
  } err_t;

  typedef enum logic [6:0] {
    M_START   = 7'b0000001,
    M_COUNT   = 7'b0000010,
    M_MANT    = 7'b0000100,
    M_EXP     = 7'b0001000,
    M_STRING  = 7'b0010000,
    M_AFTER   = 7'b0100000,
    M_DISCARD = 7'b1000000
  } mode_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [31:0]      int_value;
    logic [SigW-1:0]         real_significand;
    logic signed [ExpW-1:0]  real_exponent;
    logic                    real_negative;
    logic [7:0]              string_char;
    err_t                    error_code;
    logic                    record_end;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [1:0]          n;
    result_t [MaxRes-1:0] r;
  } group_t;

endpackage

### rtl/ipfl_front.sv
// ----------------------------------------------------------------------------
// ipfl_front
// Lexer state machine: takes one byte per cycle when in_fire is high and produces the
// group of up to three results that byte causes.
// ----------------------------------------------------------------------------
module ipfl_front #(
  parameter int unsigned HOLLERITH_COUNT_BITS = 20,
  parameter int unsigned SIGNIFICAND_DIGITS   = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            field_sep,
  input  logic [7:0]            rec_sep,
  input  logic                  in_fire,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_data,
  input  logic                  new_record,
  output ipfl_pkg::group_t      grp
);
  import ipfl_pkg::*;

  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] SigMax = CntW'(SIGNIFICAND_DIGITS);
  localparam logic [AccW-1:0] HolMax = AccW'((64'd1 << HOLLERITH_COUNT_BITS) - 64'd1);

  typedef struct packed {
    mode_t               mode;
    logic [AccW-1:0]     acc;
    logic                neg;
    logic                bad;
    logic                dot;
    logic                expo;
    logic [SigW-1:0]     sig;
    logic [CntW-1:0]     cnt;
    logic [XacW-1:0]     xac;
    logic                xneg;
    logic signed [ScW-1:0] scale;
    logic                space;
    logic [HOLLERITH_COUNT_BITS-1:0] srem;
    logic                sbad;
    logic                mdig;
    logic                xdig;
    logic                xsign;
  } lex_t;

  lex_t st, s;
  logic rec_ended, rec;
  group_t g;

  function automatic lex_t cleared();
    lex_t z;
    z = '0;
    z.mode = M_START;
    return z;
  endfunction

  function automatic logic signed [ScW-1:0] sat_add(logic signed [ScW-1:0] a,
                                                    logic signed [1:0] d);
    logic signed [ScW:0] t;
    t = {a[ScW-1], a} + {{(ScW-1){d[1]}}, d};
    if (t > $signed({1'b0, Sat16})) return $signed(Sat16);
    if (t < -$signed({1'b0, Sat16})) return -$signed(Sat16);
    return t[ScW-1:0];
  endfunction

  function automatic lex_t digit_in(lex_t a, logic [3:0] d);
    lex_t b;
    logic [AccW+3:0] p;
    b = a;
    b.mdig = 1'b1;
    p = {4'd0, a.acc} * 4'd10 + {{AccW{1'b0}}, d};
    if (p > {4'd0, AccCap}) b.acc = AccCap;
    else b.acc = p[AccW-1:0];
    if (a.sig == '0 && d == 4'd0) begin
      if (a.dot) b.scale = sat_add(a.scale, -2'sd1);
    end else if (a.cnt < SigMax) begin
      b.sig = SigW'(a.sig * 4'd10) + SigW'(d);
      b.cnt = a.cnt + 1'b1;
      if (a.dot) b.scale = sat_add(a.scale, -2'sd1);
    end else if (!a.dot) begin
      b.scale = sat_add(a.scale, 2'sd1);
    end
    return b;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_xl(logic [7:0] c);
    return c == "E" || c == "e" || c == "D" || c == "d";
  endfunction

  function automatic lex_t mant_char(lex_t a, logic [7:0] c);
    lex_t b;
    b = a;
    if (is_digit(c)) return digit_in(a, c[3:0]);
    b.mode = M_MANT;
    if (c == ".") begin
      if (a.dot) b.bad = 1'b1;
      b.dot = 1'b1;
    end else if (is_xl(c)) begin
      b.expo = 1'b1;
      b.mode = M_EXP;
    end else begin
      b.bad = 1'b1;
    end
    return b;
  endfunction

  function automatic lex_t exp_char(lex_t a, logic [7:0] c);
    lex_t b;
    logic [XacW+3:0] p;
    b = a;
    if (is_digit(c)) begin
      p = {4'd0, a.xac} * 4'd10 + {{XacW{1'b0}}, c[3:0]};
      b.xac = (p > (XacW+4)'(Sat16)) ? XacW'(Sat16) : p[XacW-1:0];
      b.xdig = 1'b1;
    end else if (c == "+" || c == "-") begin
      if (!a.xdig && !a.xsign) begin
        b.xsign = 1'b1;
        b.xneg = (c == "-");
      end else begin
        b.bad = 1'b1;
      end
    end else begin
      if (c == ".") b.dot = 1'b1;
      b.bad = 1'b1;
    end
    return b;
  endfunction

  function automatic result_t mk(kind_t k, err_t e, logic re);
    result_t r;
    r = '0;
    r.kind = k;
    r.error_code = e;
    r.record_end = re;
    return r;
  endfunction

  function automatic result_t close_res(lex_t a, logic re);
    result_t r;
    logic signed [ScW+1:0] e;
    logic [AccW-1:0] lim;
    r = mk(KIND_INT, ERR_NONE, re);
    if (a.dot || a.expo) begin
      if (a.bad || !a.mdig || (a.expo && !a.xdig)) begin
        r = mk(KIND_ERROR, ERR_BAD_REAL, re);
      end else begin
        r.kind = KIND_REAL;
        r.real_significand = a.sig;
        r.real_negative = a.neg;
        if (a.sig != '0) begin
          e = (ScW+2)'(a.scale) + (a.xneg ? -$signed({4'd0, a.xac})
                                          : $signed({4'd0, a.xac}));
          if (e > 18'sd9999) e = 18'sd9999;
          if (e < -18'sd9999) e = -18'sd9999;
          r.real_exponent = e[ExpW-1:0];
        end
      end
    end else if (a.bad || !a.mdig) begin
      r = mk(KIND_ERROR, ERR_BAD_INT, re);
    end else begin
      lim = a.neg ? AccW'(34'h0_8000_0000) : AccW'(34'h0_7FFF_FFFF);
      if (a.acc > lim) r = mk(KIND_ERROR, ERR_RANGE, re);
      else r.int_value = a.neg ? -$signed(a.acc[31:0]) : $signed(a.acc[31:0]);
    end
    return r;
  endfunction

  function automatic result_t sdone(lex_t a, logic re);
    result_t r;
    r = mk(KIND_SDONE, ERR_NONE, re);
    r.int_value = a.acc[31:0];
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic tok;
    logic [AccW-1:0] hcnt;
    c = data_byte;
    tok = 1'b0;
    hcnt = '0;
    s = st;
    rec = rec_ended;
    g = '0;
    if (new_record) begin
      rec = 1'b0;
      s = cleared();
    end
    if (rec) begin
      g.r[0] = mk(KIND_ERROR, ERR_PAST, 1'b0);
      g.n = 2'd1;
    end else begin
      unique case (s.mode)
        M_COUNT, M_MANT, M_EXP: begin
          if (c == field_sep || c == rec_sep) begin
            g.r[0] = close_res(s, c != field_sep);
            g.n = 2'd1;
            if (c != field_sep) rec = 1'b1;
            s = cleared();
          end else if (c == " ") begin
            s.space = 1'b1;
            if (s.mode == M_COUNT) s.mode = M_MANT;
          end else begin
            if (s.space) s.bad = 1'b1;
            if (s.mode == M_COUNT && (c == "H" || c == "h")) begin
              if (s.acc == '0 || s.acc > HolMax) begin
                g.r[0] = mk(KIND_ERROR, s.acc == '0 ? ERR_COUNT : ERR_OVERFLOW, 1'b0);
                g.n = 2'd1;
                s = cleared();
                s.mode = M_DISCARD;
              end else begin
                hcnt = s.acc;
                s = cleared();
                s.acc = hcnt;
                s.srem = hcnt[HOLLERITH_COUNT_BITS-1:0];
                s.mode = M_STRING;
              end
            end else if (s.mode == M_EXP) s = exp_char(s, c);
            else s = mant_char(s, c);
          end
        end
        M_STRING: begin
          if (c <= 8'h1F || c == 8'h7F) begin
            if (!s.sbad) begin
              g.r[0] = mk(KIND_ERROR, ERR_CTRL, 1'b0);
              g.n = 2'd1;
            end
            s.sbad = 1'b1;
          end else if (!s.sbad) begin
            g.r[0] = mk(KIND_SCHAR, ERR_NONE, 1'b0);
            g.r[0].string_char = c;
            g.n = 2'd1;
          end
          if (s.srem != '0) s.srem = s.srem - 1'b1;
          if (s.srem == '0) s.mode = M_AFTER;
        end
        M_AFTER: begin
          if (!s.sbad) begin
            g.r[0] = sdone(s, c == rec_sep && c != field_sep);
            g.n = 2'd1;
          end
          tok = !(c == field_sep || c == rec_sep);
          if (c == rec_sep && c != field_sep) rec = 1'b1;
          s = cleared();
          if (tok) begin
            if (c == " ") begin
            end else if (is_digit(c)) begin
              s.mode = M_COUNT;
              s = digit_in(s, c[3:0]);
            end else begin
              s.mode = M_MANT;
              if (c == "+" || c == "-") s.neg = (c == "-");
              else s = mant_char(s, c);
            end
          end
        end
        M_DISCARD: begin
          if (c == field_sep) s = cleared();
          else if (c == rec_sep) begin
            s = cleared();
            rec = 1'b1;
          end
        end
        default: begin
          if (c == " ") begin
          end else if (c == field_sep) begin
            g.r[0] = mk(KIND_DEFAULT, ERR_NONE, 1'b0);
            g.n = 2'd1;
          end else if (c == rec_sep) begin
            g.r[0] = mk(KIND_DEFAULT, ERR_NONE, 1'b1);
            g.n = 2'd1;
            rec = 1'b1;
          end else if (is_digit(c)) begin
            s.mode = M_COUNT;
            s = digit_in(s, c[3:0]);
          end else begin
            s.mode = M_MANT;
            if (c == "+" || c == "-") s.neg = (c == "-");
            else s = mant_char(s, c);
          end
        end
      endcase
      if (end_of_data) begin
        unique case (s.mode)
          M_COUNT, M_MANT, M_EXP: begin
            g.r[g.n] = close_res(s, 1'b0);
            g.n = g.n + 1'b1;
          end
          M_STRING: begin
            g.r[g.n] = mk(KIND_ERROR, ERR_OVERFLOW, 1'b0);
            g.n = g.n + 1'b1;
          end
          M_AFTER: begin
            if (!s.sbad) begin
              g.r[g.n] = sdone(s, 1'b0);
              g.n = g.n + 1'b1;
            end
          end
          default: ;
        endcase
        s = cleared();
        if (!rec) begin
          g.r[g.n] = mk(KIND_ERROR, ERR_END, 1'b0);
          g.n = g.n + 1'b1;
          rec = 1'b1;
        end
      end
    end
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i + 1) == g.n) g.r[i].last = 1'b1;
    end
  end

  assign grp = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cleared();
      rec_ended <= 1'b0;
    end else if (in_fire) begin
      st <= s;
      rec_ended <= rec;
    end
  end

endmodule

### rtl/ipfl_back.sv
// ----------------------------------------------------------------------------
// ipfl_back
// Result queue and serializer: holds byte groups and hands out their
// results one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ipfl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ipfl_pkg::group_t     push_grp,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipfl_pkg::result_t    out_res
);
  import ipfl_pkg::*;

  localparam int unsigned Depth = 4;

  group_t     mem [Depth];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic [1:0] idx;
  logic       pop_res, pop_grp, do_push;

  assign do_push  = push && push_grp.n != 2'd0;
  assign can_push = cnt < 3'(Depth);
  assign out_valid = cnt != 3'd0;
  assign out_res  = mem[rp].r[idx];
  assign pop_res  = out_valid && out_ready;
  assign pop_grp  = pop_res && (2'(idx + 1'b1) == mem[rp].n);

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      idx <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (pop_grp) begin
        rp <= rp + 1'b1;
        idx <= '0;
      end else if (pop_res) begin
        idx <= idx + 1'b1;
      end
      cnt <= cnt + 3'(do_push) - 3'(pop_grp);
    end
  end

endmodule

### rtl/iges_param_field_lexer.sv
// The results of a byte are written into the result queue when the byte is taken.
// One byte is taken per cycle while the queue has room; a byte with k results hands them out in turn.
// A four-group result queue decouples the lexer from the output; input stalls when it is full.
// Reset: synchronous, lexer to field start, delimiters to ',' and ';', queue empty.
// ----------------------------------------------------------------------------
// iges_param_field_lexer
// IGES free-format parameter field tokenizer, top level.
// ----------------------------------------------------------------------------
module iges_param_field_lexer #(
  parameter int unsigned HOLLERITH_COUNT_BITS = 20,
  parameter int unsigned SIGNIFICAND_DIGITS   = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_data,
  input  logic                new_record,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          kind,
  output logic signed [31:0]  int_value,
  output logic [59:0]         real_significand,
  output logic signed [14:0]  real_exponent,
  output logic                real_negative,
  output logic [7:0]          string_char,
  output logic [3:0]          error_code,
  output logic                record_end,
  output logic                last
);
  import ipfl_pkg::*;

  logic [7:0] field_sep, rec_sep;
  group_t grp;
  result_t res;
  logic can_push, in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      field_sep <= 8'd44;
      rec_sep <= 8'd59;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_REC_SEP) rec_sep <= cfg_data;
      else field_sep <= cfg_data;
    end
  end

  assign in_ready = can_push;
  assign in_fire = in_valid && in_ready;

  ipfl_front #(
    .HOLLERITH_COUNT_BITS(HOLLERITH_COUNT_BITS),
    .SIGNIFICAND_DIGITS(SIGNIFICAND_DIGITS)
  ) u_front (
    .clk, .rst, .field_sep, .rec_sep, .in_fire,
    .data_byte, .end_of_data, .new_record, .grp
  );

  ipfl_back u_back (
    .clk, .rst, .push(in_fire), .push_grp(grp), .can_push,
    .out_valid, .out_ready, .out_res(res)
  );

  assign kind = res.kind;
  assign int_value = res.int_value;
  assign real_significand = res.real_significand;
  assign real_exponent = res.real_exponent;
  assign real_negative = res.real_negative;
  assign string_char = res.string_char;
  assign error_code = res.error_code;
  assign record_end = res.record_end;
  assign last = res.last;

endmodule

### rtl/ipfl_checker.sv
// ----------------------------------------------------------------------------
// ipfl_checker
// Port-level checks on the lexer's result channel.
// ----------------------------------------------------------------------------
module ipfl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [3:0]  error_code,
  input logic [7:0]  string_char
);
  import ipfl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind)) else $error("out hold");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE) else $error("err code");
  a_chr: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SCHAR |-> string_char == 8'd0) else $error("char");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= 3'd5) else $error("kind");
endmodule

bind iges_param_field_lexer ipfl_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .kind, .error_code, .string_char
);
